// ===== hw/rtl/ipss_pkg.sv =====
`timescale 1ns / 1ps

package ipss_pkg;

  localparam int LEVEL_BITS_DEF = 16;

  localparam int AMP_W      = 16;
  localparam int RAMP_W     = 12;
  localparam int TICKS_W    = 8;
  localparam int ELEC_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [AMP_W-1:0]  LEVEL_OUT_MAX = 16'hFFFF;
  localparam logic [ELEC_W-1:0] ELEC_NONE     = 4'h0;
  localparam logic [ELEC_W-1:0] ELEC_FIRST    = 4'h1;
  localparam logic [ELEC_W-1:0] ELEC_LOW3     = 4'h7;
  localparam logic [ELEC_W-1:0] ELEC_ALL      = 4'hF;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_BACK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 2'd2;

  localparam logic [RAMP_W-1:0]  RAMP_STEP_RST    = 12'd50;
  localparam logic [TICKS_W-1:0] HOLD_TICKS_RST   = 8'd100;
  localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST = 8'd50;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FWD_RAMP,
    PH_FWD_HOLD,
    PH_BACK_SETTLE,
    PH_BACK_HOLD,
    PH_BACK_RAMP
  } phase_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [AMP_W-1:0] amplitude;
  } in_item_t;

  typedef struct packed {
    logic [AMP_W-1:0]  walk_level;
    logic [ELEC_W-1:0] electrodes;
    logic              busy_res;
    logic              step_done;
    logic              rejected;
  } out_item_t;

  typedef struct packed {
    logic [RAMP_W-1:0]  ramp_step;
    logic [TICKS_W-1:0] hold_ticks;
    logic [TICKS_W-1:0] settle_ticks;
  } cfg_t;

endpackage

// ===== hw/rtl/inertial_piezo_step_sequencer_top.sv =====
`timescale 1ns / 1ps

// Step sequencer for a four-electrode stick-slip piezo walker. Every request
// (tick, start forward, start back) gives exactly one result with the walk
// level, electrode bits and status flags. One request is taken per clock
// while in_stall is low; a request is captured in the input register,
// then the sequencer state and the result register update from it
// together once the result register can take it. The input register lets one more
// request in while a result waits on out_stall. Configuration writes are
// taken every cycle (cfg_ready is always high).

module inertial_piezo_step_sequencer_top import ipss_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t res;
  logic      adv, in_acc;

  assign cfg_ready = 1'b1;

  ipss_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ipss_seq #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.step_done && out_data_r.busy_res))
    else $error("step_done with busy_res set");

  a_done_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.step_done && out_data_r.rejected))
    else $error("step_done and rejected together");

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.rejected) |-> out_data_r.busy_res)
    else $error("rejected while not busy");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result lost after advance");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room to advance");

endmodule

// ===== hw/rtl/ipss_cfg.sv =====
`timescale 1ns / 1ps

module ipss_cfg import ipss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_step    <= RAMP_STEP_RST;
      cfg_r.hold_ticks   <= HOLD_TICKS_RST;
      cfg_r.settle_ticks <= SETTLE_TICKS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RAMP_STEP:    cfg_r.ramp_step    <= wr_data[RAMP_W-1:0];
        REG_HOLD_TICKS:   cfg_r.hold_ticks   <= wr_data[TICKS_W-1:0];
        REG_SETTLE_TICKS: cfg_r.settle_ticks <= wr_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/ipss_seq.sv =====
`timescale 1ns / 1ps

module ipss_seq import ipss_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  localparam int EW = ((LEVEL_BITS > RAMP_W) ? LEVEL_BITS : RAMP_W) + 1;
  localparam int OW = (LEVEL_BITS > AMP_W) ? LEVEL_BITS : AMP_W;
  localparam logic [LEVEL_BITS-1:0] FS = {LEVEL_BITS{1'b1}};

  phase_t                  phase_r, phase_nxt;
  logic [LEVEL_BITS-1:0]   level_r, level_nxt;
  logic [LEVEL_BITS-1:0]   target_r, target_nxt;
  logic [ELEC_W-1:0]       bits_r, bits_nxt;
  logic [TICKS_W-1:0]      wait_r, wait_nxt;
  logic                    done, rej;

  logic [RAMP_W-1:0]       st;
  logic [OW-1:0]           amp_ext;
  logic [LEVEL_BITS-1:0]   amp_c;
  logic [EW-1:0]           up_sum, dn_diff;
  logic [LEVEL_BITS-1:0]   up_lvl, dn_lvl;
  logic                    wait_exp;
  logic [OW-1:0]           lvl_ow;
  logic                    is_idle;

  assign st       = (cfg.ramp_step == '0) ? RAMP_W'(1) : cfg.ramp_step;
  assign amp_ext  = OW'(item.amplitude);
  assign amp_c    = (amp_ext > OW'(FS)) ? FS : amp_ext[LEVEL_BITS-1:0];
  assign up_sum   = EW'(level_r) + EW'(st);
  assign up_lvl   = (up_sum > EW'(FS)) ? FS : up_sum[LEVEL_BITS-1:0];
  assign dn_diff  = EW'(level_r) - EW'(st);
  assign dn_lvl   = (EW'(level_r) > EW'(st)) ? dn_diff[LEVEL_BITS-1:0] : '0;
  assign wait_exp = (wait_r <= TICKS_W'(1));
  assign is_idle  = (phase_r == PH_IDLE);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item.cmd == CMD_TICK) begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_FWD_RAMP:
          if (up_lvl >= target_r) phase_nxt = PH_FWD_HOLD;
        PH_FWD_HOLD:
          if (wait_exp && bits_r == ELEC_NONE) phase_nxt = PH_IDLE;
        PH_BACK_SETTLE:
          if (wait_exp) phase_nxt = PH_BACK_HOLD;
        PH_BACK_HOLD:
          if (wait_exp && bits_r == ELEC_ALL) begin
            phase_nxt = (level_r == '0) ? PH_IDLE : PH_BACK_RAMP;
          end
        PH_BACK_RAMP:
          if (dn_lvl == '0) phase_nxt = PH_IDLE;
        default: phase_nxt = PH_IDLE;
      endcase
    end else if (is_idle && item.cmd == CMD_FWD) begin
      phase_nxt = (amp_c == '0) ? PH_FWD_HOLD : PH_FWD_RAMP;
    end else if (is_idle && item.cmd == CMD_BACK) begin
      phase_nxt = (cfg.settle_ticks == '0) ? PH_BACK_HOLD : PH_BACK_SETTLE;
    end
  end

  // datapath and result
  always_comb begin
    level_nxt  = level_r;
    target_nxt = target_r;
    bits_nxt   = bits_r;
    wait_nxt   = wait_r;
    done       = 1'b0;
    rej        = 1'b0;
    if (item.cmd == CMD_TICK) begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_FWD_RAMP: begin
          level_nxt = up_lvl;
          if (up_lvl >= target_r) begin
            bits_nxt = bits_r & ELEC_LOW3;
            wait_nxt = cfg.hold_ticks;
          end
        end
        PH_FWD_HOLD: begin
          if (!wait_exp) begin
            wait_nxt = wait_r - TICKS_W'(1);
          end else if (bits_r == ELEC_NONE) begin
            wait_nxt = '0;
            done     = 1'b1;
          end else begin
            bits_nxt = bits_r >> 1;
            wait_nxt = cfg.hold_ticks;
          end
        end
        PH_BACK_SETTLE: begin
          if (!wait_exp) begin
            wait_nxt = wait_r - TICKS_W'(1);
          end else begin
            bits_nxt = bits_r | ELEC_FIRST;
            wait_nxt = cfg.hold_ticks;
          end
        end
        PH_BACK_HOLD: begin
          if (!wait_exp) begin
            wait_nxt = wait_r - TICKS_W'(1);
          end else if (bits_r == ELEC_ALL) begin
            wait_nxt = '0;
            if (level_r == '0) begin
              bits_nxt = ELEC_NONE;
              done     = 1'b1;
            end
          end else begin
            bits_nxt = (bits_r << 1) | ELEC_FIRST;
            wait_nxt = cfg.hold_ticks;
          end
        end
        PH_BACK_RAMP: begin
          level_nxt = dn_lvl;
          if (dn_lvl == '0) begin
            bits_nxt = ELEC_NONE;
            done     = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (item.cmd == CMD_FWD || item.cmd == CMD_BACK) begin
      if (!is_idle) begin
        rej = 1'b1;
      end else if (item.cmd == CMD_FWD) begin
        target_nxt = amp_c;
        level_nxt  = '0;
        if (amp_c == '0) begin
          bits_nxt = ELEC_LOW3;
          wait_nxt = cfg.hold_ticks;
        end else begin
          bits_nxt = ELEC_ALL;
        end
      end else begin
        target_nxt = amp_c;
        level_nxt  = amp_c;
        if (cfg.settle_ticks == '0) begin
          bits_nxt = ELEC_FIRST;
          wait_nxt = cfg.hold_ticks;
        end else begin
          bits_nxt = ELEC_NONE;
          wait_nxt = cfg.settle_ticks;
        end
      end
    end
  end

  assign lvl_ow = OW'(level_nxt);

  always_comb begin
    res.walk_level = (lvl_ow > OW'(LEVEL_OUT_MAX)) ? LEVEL_OUT_MAX : lvl_ow[AMP_W-1:0];
    res.electrodes = bits_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.step_done  = done;
    res.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      level_r  <= '0;
      target_r <= '0;
      bits_r   <= ELEC_NONE;
      wait_r   <= '0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      level_r  <= level_nxt;
      target_r <= target_nxt;
      bits_r   <= bits_nxt;
      wait_r   <= wait_nxt;
    end
  end

endmodule
